// ----- rtl/core/lmtp_pkg.sv -----
// shared types, constants and codes of the led matrix transition pixel core
package lmtp_pkg;

	// matrix geometry and field widths
	localparam int Width  = 32;
	localparam int Height = 8;
	localparam int Depth  = Width * Height;
	localparam int ColW   = 5;
	localparam int RowW   = 3;
	localparam int AddrW  = ColW + RowW;
	localparam int ChanW  = 8;
	localparam int PixW   = 3 * ChanW;
	localparam int ProgW  = 11;
	localparam int FacW   = 9;

	// unity scale factor, (c * 256) >> 8 == c
	localparam logic [FacW-1:0] FacFull = 9'd256;

	// register byte addresses, word index in bit 2
	localparam logic RegEffect = 1'b0;

	typedef enum logic [1:0] {
		ActLoadOut = 2'd0,
		ActLoadIn  = 2'd1,
		ActRender  = 2'd2,
		ActNone    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		EffFade    = 3'd0,
		EffWipe    = 3'd1,
		EffSlideL  = 3'd2,
		EffBlink   = 3'd3,
		EffSlideR  = 3'd4,
		EffCurtain = 3'd5,
		EffRipple  = 3'd6,
		EffXfade   = 3'd7
	} effect_t;

	// per pixel blend control handed from effect decode to blend
	typedef struct packed {
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic            xfade;
		logic [FacW-1:0] fac;
	} render_ctl_t;

endpackage

// ----- rtl/core/lmtp_ram.sv -----
// generic single write port ram with registered read
module lmtp_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/lmtp_fx.sv -----
// effect decode: source address and blend factor for one rendered pixel
module lmtp_fx (
	input  lmtp_pkg::effect_t           effect,
	input  logic [lmtp_pkg::ColW-1:0]   col,
	input  logic [lmtp_pkg::RowW-1:0]   row,
	input  logic [lmtp_pkg::ProgW-1:0]  progress,
	output lmtp_pkg::render_ctl_t       ctl,
	output logic [lmtp_pkg::AddrW-1:0]  rd_addr
);
	import lmtp_pkg::*;

	logic [9:0]  p10;
	logic        done;
	logic [4:0]  shift;
	logic [5:0]  sum_l;
	logic [15:0] wipe_prod;
	logic [17:0] dim_prod;
	logic [7:0]  dim;
	logic [12:0] blink5;
	logic [10:0] cur_diff;
	logic [4:0]  cur_t;
	logic [4:0]  cur_d;
	logic [13:0] x10;
	logic [13:0] base;
	logic [13:0] rx;
	logic [20:0] rp;
	logic [10:0] rq;
	logic [7:0]  rdim;

	// progress terms shared by the effects
	always_comb begin
		p10       = progress[9:0];
		done      = progress[10];
		shift     = p10[9:5];
		sum_l     = {1'b0, col} + {1'b0, shift};
		wipe_prod = {6'd0, p10} * 16'd33;
		dim_prod  = {8'd0, p10} * 18'd255;
		dim       = dim_prod[17:10];
		blink5    = {3'd0, p10} * 13'd5;
		cur_diff  = 11'd1024 - {1'b0, p10};
		cur_t     = cur_diff[10:6];
		cur_d     = col[4] ? {1'b0, col[3:0]} : 5'(Width / 2) - col;
		x10       = {4'd0, p10} * 14'd10;
		base      = (col[0] ^ row[0]) ? 14'd6656 : 14'd3584;
		rx        = x10 - base;
		rp        = {7'd0, rx} * 21'd85;
		rq        = rp[20:10];
		rdim      = (rq > 11'd255) ? 8'd255 : rq[7:0];
	end

	// per effect source and factor, black is a zero scale
	always_comb begin
		ctl.col   = col;
		ctl.row   = row;
		ctl.xfade = 1'b0;
		ctl.fac   = FacFull;
		rd_addr   = {row, col};
		case (effect)
			EffFade: begin
				ctl.fac = FacFull - {1'b0, dim};
			end
			EffWipe: begin
				if ({1'b0, col} < wipe_prod[15:10]) begin
					ctl.fac = '0;
				end
			end
			EffSlideL: begin
				rd_addr = {row, sum_l[4:0]};
				if (sum_l[5]) begin
					ctl.fac = '0;
				end
			end
			EffBlink: begin
				if (blink5[12] || blink5[10]) begin
					ctl.fac = '0;
				end
			end
			EffSlideR: begin
				rd_addr = {row, col - shift};
				if (col < shift) begin
					ctl.fac = '0;
				end
			end
			EffCurtain: begin
				if (cur_d >= cur_t) begin
					ctl.fac = '0;
				end
			end
			EffRipple: begin
				if (x10 > base) begin
					ctl.fac = FacFull - {1'b0, rdim};
				end
			end
			EffXfade: begin
				ctl.xfade = 1'b1;
				ctl.fac   = {1'b0, dim};
			end
			default: begin
				ctl.fac = '0;
			end
		endcase
		// complete transition renders black
		if (done) begin
			ctl.xfade = 1'b0;
			ctl.fac   = '0;
		end
	end

endmodule

// ----- rtl/core/lmtp_blend.sv -----
// per channel scale or crossfade: multiply stage and final add
module lmtp_blend (
	input  logic                        clk,
	input  logic                        en,
	input  lmtp_pkg::render_ctl_t       ctl_in,
	input  logic [lmtp_pkg::PixW-1:0]   opix,
	input  logic [lmtp_pkg::PixW-1:0]   ipix,
	output lmtp_pkg::render_ctl_t       ctl_out,
	output logic [lmtp_pkg::PixW-1:0]   pix
);
	import lmtp_pkg::*;

	logic [ChanW-1:0] hi      [3];
	logic [ChanW-1:0] hi_s3   [3];
	logic [PixW-1:0]  opix_s3;
	render_ctl_t      ctl_s3;

	// one multiplier per channel: old * fac, or (new - old) * mix
	always_comb begin
		logic [8:0]  o9;
		logic [8:0]  a9;
		logic [15:0] a16;
		logic [15:0] prod;
		for (int ch = 0; ch < 3; ch++) begin
			o9   = {1'b0, opix[ch*ChanW +: ChanW]};
			a9   = ctl_in.xfade ? ({1'b0, ipix[ch*ChanW +: ChanW]} - o9) : o9;
			a16  = {{7{a9[8]}}, a9};
			prod = a16 * {7'd0, ctl_in.fac};
			hi[ch] = prod[15:8];
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				hi_s3[ch] <= hi[ch];
			end
			opix_s3 <= opix;
			ctl_s3  <= ctl_in;
		end
	end

	// crossfade adds the floored signed step to the old channel
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			pix[ch*ChanW +: ChanW] = ctl_s3.xfade ?
				opix_s3[ch*ChanW +: ChanW] + hi_s3[ch] : hi_s3[ch];
		end
	end

	assign ctl_out = ctl_s3;

endmodule

// ----- rtl/core/led_matrix_transition_pixel_core.sv -----
// a render word passes the stage 1, 2, 3 and 4 registers before it leaves; loads give no word
// one word per cycle while rsp_stall is low, loads and renders mixed freely
// the rate is set by the two frame rams, each with one write and one read per cycle
// stalls back up stage by stage, empty stages fill while the output waits
// reset clears stage valid bits and the effect register; frame rams are not cleared
module led_matrix_transition_pixel_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  action,
	input  logic [lmtp_pkg::ColW-1:0]   col,
	input  logic [lmtp_pkg::RowW-1:0]   row,
	input  logic [lmtp_pkg::ChanW-1:0]  red,
	input  logic [lmtp_pkg::ChanW-1:0]  green,
	input  logic [lmtp_pkg::ChanW-1:0]  blue,
	input  logic [lmtp_pkg::ProgW-1:0]  progress,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [lmtp_pkg::ColW-1:0]   out_col,
	output logic [lmtp_pkg::RowW-1:0]   out_row,
	output logic [lmtp_pkg::ChanW-1:0]  out_red,
	output logic [lmtp_pkg::ChanW-1:0]  out_green,
	output logic [lmtp_pkg::ChanW-1:0]  out_blue
);
	import lmtp_pkg::*;

	effect_t          effect_q;
	logic             cfg_wr;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	action_t          act_s1;
	logic [ColW-1:0]  col_s1;
	logic [RowW-1:0]  row_s1;
	logic [PixW-1:0]  rgb_s1;
	logic [ProgW-1:0] prog_s1;

	render_ctl_t      ctl_fx;
	logic [AddrW-1:0] out_raddr;
	logic [AddrW-1:0] pix_addr;
	logic             out_we, in_we;
	logic [PixW-1:0]  opix, ipix;

	render_ctl_t      ctl_s2;
	render_ctl_t      ctl_s3;
	logic [PixW-1:0]  pix_s3;
	logic [PixW-1:0]  pix_s4;
	logic [ColW-1:0]  col_s4;
	logic [RowW-1:0]  row_s4;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_q <= EffFade;
		end else if (cfg_wr && (paddr[2] == RegEffect)) begin
			effect_q <= effect_t'(pwdata[2:0]);
		end
	end

	assign prdata = (paddr[2] == RegEffect) ? {29'd0, effect_q} : 32'd0;

	// stage ready chain, a stage takes a word when empty or when it moves on
	assign rdy_s4    = !vld_s4 || !rsp_stall;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign req_stall = !rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= req_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1 && (act_s1 == ActRender);
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// stage 1: registered request
	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			act_s1  <= action_t'(action);
			col_s1  <= col;
			row_s1  <= row;
			rgb_s1  <= {red, green, blue};
			prog_s1 <= progress;
		end
	end

	// effect decode on stage 1
	lmtp_fx u_fx (
		.effect   (effect_q),
		.col      (col_s1),
		.row      (row_s1),
		.progress (prog_s1),
		.ctl      (ctl_fx),
		.rd_addr  (out_raddr)
	);

	// frame writes and reads issue together as stage 1 moves on, so order holds
	assign pix_addr = {row_s1, col_s1};
	assign out_we   = vld_s1 && (act_s1 == ActLoadOut) && rdy_s2;
	assign in_we    = vld_s1 && (act_s1 == ActLoadIn) && rdy_s2;

	lmtp_ram #(
		.DATA_W (PixW),
		.DEPTH  (Depth)
	) u_out_frame (
		.clk   (clk),
		.we    (out_we),
		.waddr (pix_addr),
		.wdata (rgb_s1),
		.re    (rdy_s2),
		.raddr (out_raddr),
		.rdata (opix)
	);

	lmtp_ram #(
		.DATA_W (PixW),
		.DEPTH  (Depth)
	) u_in_frame (
		.clk   (clk),
		.we    (in_we),
		.waddr (pix_addr),
		.wdata (rgb_s1),
		.re    (rdy_s2),
		.raddr (pix_addr),
		.rdata (ipix)
	);

	// stage 2: blend control, aligned with ram read data
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			ctl_s2 <= ctl_fx;
		end
	end

	// stages 2 and 3: multiply, then add
	lmtp_blend u_blend (
		.clk     (clk),
		.en      (rdy_s3),
		.ctl_in  (ctl_s2),
		.opix    (opix),
		.ipix    (ipix),
		.ctl_out (ctl_s3),
		.pix     (pix_s3)
	);

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			pix_s4 <= pix_s3;
			col_s4 <= ctl_s3.col;
			row_s4 <= ctl_s3.row;
		end
	end

	assign rsp_valid = vld_s4;
	assign out_col   = col_s4;
	assign out_row   = row_s4;
	assign out_red   = pix_s4[3*ChanW-1:2*ChanW];
	assign out_green = pix_s4[2*ChanW-1:ChanW];
	assign out_blue  = pix_s4[ChanW-1:0];

`ifndef ASSERT_OFF
	// one item never loads both frames
	a_one_frame_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_we && in_we))
		else $error("both frame rams written in one cycle");

	// crossfade mix stays below unity, scale factor never above unity
	a_fac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (ctl_s2.xfade ? (ctl_s2.fac < FacFull) : (ctl_s2.fac <= FacFull)))
		else $error("blend factor out of range");

	// a blocked word in stage 3 is not dropped
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !rdy_s4) |=> vld_s3)
		else $error("stage 3 word lost under stall");

	// a render leaving stage 1 shows up in stage 2
	a_render_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (act_s1 == ActRender) && rdy_s2) |=> vld_s2)
		else $error("render word lost between stage 1 and stage 2");
`endif

endmodule
